// ----- rtl/sensor_temp_press_hum_compensation_assert.svh -----
// Assertion macros for the compensation block.
// Used by the top level only; needs nothing else.
`ifndef SENSOR_TEMP_PRESS_HUM_COMPENSATION_ASSERT_SVH
`define SENSOR_TEMP_PRESS_HUM_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define STCMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stcmp assertion failed");

// next-cycle implication
`define STCMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stcmp assertion failed");

`endif

// ----- rtl/stcmp_pkg.sv -----
// Shared types, constants and shift helpers for the compensation block.
// No dependencies.
`default_nettype none
package stcmp_pkg;

    localparam int unsigned LAT     = 81;
    localparam int unsigned DIV_W   = 64;
    localparam int unsigned TF_DLY  = 77;
    localparam int unsigned TMP_DLY = 76;
    localparam int unsigned HUM_DLY = 70;

    typedef enum logic [2:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LOW  = 3'd1,
        CFG_PRESS_HIGH = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_HUM_A      = 3'd4,
        CFG_HUM_B      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] adc_temp;
        logic [19:0] adc_press;
        logic [15:0] adc_hum;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure;
        logic               pressure_invalid;
        logic [16:0]        humidity;
    } t_out;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_div_side;

    function automatic logic [31:0] sra32(logic [31:0] x, int unsigned s);
        logic signed [31:0] t;
        t = $signed(x);
        return 32'(t >>> s);
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int unsigned s);
        logic signed [63:0] t;
        t = $signed(x);
        return 64'(t >>> s);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/stcmp_mul64.sv -----
// Two-stage 64 x 64 multiplier, low 64 bits of the product.
// Uses three 32 x 32 partial products; no package dependency.
`default_nettype none
module stcmp_mul64 (
    input  wire logic        i_clk,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic [63:0]      o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_ll <= {32'b0, i_a[31:0]} * {32'b0, i_b[31:0]};
        r_lh <= i_a[31:0] * i_b[63:32];
        r_hl <= i_a[63:32] * i_b[31:0];
        r_p  <= r_ll + {32'(r_lh + r_hl), 32'b0};
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- rtl/stcmp_div.sv -----
// Pipelined restoring divider, unsigned 64 / 64, one quotient bit per stage.
// Depends on stcmp_pkg for the stage count and the side-band type.
`default_nettype none
module stcmp_div import stcmp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    input  wire t_div_side   i_side,
    output logic [63:0]      o_quo,
    output t_div_side        o_side
);
    logic [63:0] r_rem  [DIV_W];
    logic [63:0] r_num  [DIV_W];
    logic [63:0] r_den  [DIV_W];
    t_div_side   r_side [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stg
        logic [63:0] rem_in;
        logic [63:0] num_in;
        logic [63:0] den_in;
        t_div_side   side_in;
        logic [64:0] sh;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_rest
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign sh = {rem_in, num_in[63]};
        assign ge = sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? 64'(sh - {1'b0, den_in}) : sh[63:0];
            r_num[k]  <= {num_in[62:0], ge};
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_quo  = r_num[DIV_W-1];
    assign o_side = r_side[DIV_W-1];
endmodule
`default_nettype wire

// ----- rtl/sensor_temp_press_hum_compensation.sv -----
// Top level: integer temperature, pressure and humidity compensation pipeline.
// Depends on stcmp_pkg, stcmp_mul64, stcmp_div and the assertion macro header.
//
// Usage:
//   Command channel: a measurement set on i_data is taken at a rising edge where
//   start is high and busy is low. busy is high only during reset and until
//   the run flag is registered after it; afterwards one set may enter on every cycle.
//   Result channel: o_valid marks one beat on o_result for exactly one cycle.
//   Results leave in order, one per set. Throughput is one set per cycle; the
//   pressure path is the longest: 64 divider stages (one quotient bit each) plus
//   five two-stage 64-bit multipliers in series with their add stages.
//   Temperature and humidity finish early and wait in delay lines.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at the edge;
//   indexes beyond the list are dropped. Write only while no set is in flight.
//   Reset clears the coefficients and all valid bits. The receiver cannot stall:
//   a result is on the ports for its one cycle only.
`default_nettype none
`include "sensor_temp_press_hum_compensation_assert.svh"
module sensor_temp_press_hum_compensation import stcmp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in         i_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    output t_out             o_result
);
    logic [47:0] r_cfg_t;
    logic [63:0] r_cfg_pl;
    logic [63:0] r_cfg_ph;
    logic [15:0] r_cfg_p9;
    logic [39:0] r_cfg_ha;
    logic [31:0] r_cfg_hb;
    logic        r_run;
    logic [LAT:1] r_vld;
    logic        acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t  <= '0;
            r_cfg_pl <= '0;
            r_cfg_ph <= '0;
            r_cfg_p9 <= '0;
            r_cfg_ha <= '0;
            r_cfg_hb <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP:       r_cfg_t  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_cfg_pl <= i_cfg_data;
                CFG_PRESS_HIGH: r_cfg_ph <= i_cfg_data;
                CFG_PRESS_NINE: r_cfg_p9 <= i_cfg_data[15:0];
                CFG_HUM_A:      r_cfg_ha <= i_cfg_data[39:0];
                CFG_HUM_B:      r_cfg_hb <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign busy = !r_run;
    assign acc  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
        end else begin
            r_run <= 1'b1;
            r_vld <= {r_vld[LAT-1:1], acc};
        end
    end

    // coefficient fields
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'b0, r_cfg_t[15:0]};
    assign t2 = {{16{r_cfg_t[31]}}, r_cfg_t[31:16]};
    assign t3 = {{16{r_cfg_t[47]}}, r_cfg_t[47:32]};
    assign h1 = {24'b0, r_cfg_ha[7:0]};
    assign h2 = {{16{r_cfg_ha[23]}}, r_cfg_ha[23:8]};
    assign h3 = {24'b0, r_cfg_ha[31:24]};
    assign h6 = {{24{r_cfg_ha[39]}}, r_cfg_ha[39:32]};
    assign h4 = {{16{r_cfg_hb[15]}}, r_cfg_hb[15:0]};
    assign h5 = {{16{r_cfg_hb[31]}}, r_cfg_hb[31:16]};
    assign p1 = {48'b0, r_cfg_pl[15:0]};
    assign p2 = {{48{r_cfg_pl[31]}}, r_cfg_pl[31:16]};
    assign p3 = {{48{r_cfg_pl[47]}}, r_cfg_pl[47:32]};
    assign p4 = {{48{r_cfg_pl[63]}}, r_cfg_pl[63:48]};
    assign p5 = {{48{r_cfg_ph[15]}}, r_cfg_ph[15:0]};
    assign p6 = {{48{r_cfg_ph[31]}}, r_cfg_ph[31:16]};
    assign p7 = {{48{r_cfg_ph[47]}}, r_cfg_ph[47:32]};
    assign p8 = {{48{r_cfg_ph[63]}}, r_cfg_ph[63:48]};
    assign p9 = {{48{r_cfg_p9[15]}}, r_cfg_p9};

    // temperature
    logic [31:0] at, td;
    logic [31:0] r_m1, r_dd, r_v1, r_q, r_tf, r_temp;
    logic [19:0] r_apd [8];
    logic [15:0] r_ahd [4];

    assign at = {12'b0, i_data.adc_temp};
    assign td = (at >> 3'd4) - t1;

    always_ff @(posedge i_clk) begin
        r_m1   <= ((at >> 3'd3) - (t1 << 1)) * t2;
        r_dd   <= td * td;
        r_v1   <= sra32(r_m1, 11);
        r_q    <= sra32(r_dd, 12) * t3;
        r_tf   <= r_v1 + sra32(r_q, 14);
        r_temp <= sra32(r_tf * 32'd5 + 32'd128, 8);
        r_apd[0] <= i_data.adc_press;
        r_ahd[0] <= i_data.adc_hum;
        for (int i = 1; i < 8; i++) r_apd[i] <= r_apd[i-1];
        for (int i = 1; i < 4; i++) r_ahd[i] <= r_ahd[i-1];
    end

    // humidity
    logic [31:0] hx;
    logic [31:0] r_h5x, r_xh6, r_xh3, r_ha5, r_inner, r_hbt, r_ha6;
    logic [31:0] r_hx7, r_hx8, r_xsq, r_hx9, r_hm, hxs, hx2, hxc;
    logic [16:0] r_hum;

    assign hx  = r_tf - 32'd76800;
    assign hxs = sra32(r_hx7, 15);
    assign hx2 = r_hx9 - sra32(r_hm, 4);

    always_comb begin
        hxc = hx2;
        if (hx2[31]) begin
            hxc = '0;
        end else if (hx2 > 32'd419430400) begin
            hxc = 32'd419430400;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h5x   <= h5 * hx;
        r_xh6   <= hx * h6;
        r_xh3   <= hx * h3;
        r_ha5   <= sra32(({16'b0, r_ahd[3]} << 14) - (h4 << 20) - r_h5x + 32'd16384, 15);
        r_inner <= sra32(r_xh6, 10) * (sra32(r_xh3, 11) + 32'd32768);
        r_hbt   <= (sra32(r_inner, 10) + 32'd2097152) * h2;
        r_ha6   <= r_ha5;
        r_hx7   <= r_ha6 * sra32(r_hbt + 32'd8192, 14);
        r_xsq   <= hxs * hxs;
        r_hx8   <= r_hx7;
        r_hm    <= sra32(r_xsq, 7) * h1;
        r_hx9   <= r_hx8;
        r_hum   <= hxc[28:12];
    end

    // pressure
    logic [63:0] a0, m_aa, m_ap5, m_ap2, m_b1, m_a1, m_d, m_e, m_f1, m_f2, m_g;
    logic [63:0] r_ap5d [2];
    logic [63:0] r_ap2d [2];
    logic [63:0] r_b, r_a, r_ua, r_ub, a_fin, pd, quo, r_p, ps;
    t_div_side   r_side, div_side;
    logic [63:0] r_pd  [4];
    logic [63:0] r_sd  [2];
    logic [63:0] r_c2d [2];
    logic        r_zd  [5];

    assign a0 = {{32{r_tf[31]}}, r_tf} - 64'd128000;
    assign pd = 64'd1048576 - {44'b0, r_apd[7]};
    assign a_fin = sra64(m_d, 33);
    assign ps = sra64(r_p, 13);

    stcmp_mul64 u_mul_aa  (.i_clk(i_clk), .i_a(a0),    .i_b(a0), .o_p(m_aa));
    stcmp_mul64 u_mul_ap5 (.i_clk(i_clk), .i_a(a0),    .i_b(p5), .o_p(m_ap5));
    stcmp_mul64 u_mul_ap2 (.i_clk(i_clk), .i_a(a0),    .i_b(p2), .o_p(m_ap2));
    stcmp_mul64 u_mul_b1  (.i_clk(i_clk), .i_a(m_aa),  .i_b(p6), .o_p(m_b1));
    stcmp_mul64 u_mul_a1  (.i_clk(i_clk), .i_a(m_aa),  .i_b(p3), .o_p(m_a1));
    stcmp_mul64 u_mul_d   (.i_clk(i_clk), .i_a(64'h0000_8000_0000_0000 + r_a),
                           .i_b(p1), .o_p(m_d));
    stcmp_mul64 u_mul_e   (.i_clk(i_clk), .i_a((pd << 31) - r_b),
                           .i_b(64'd3125), .o_p(m_e));
    stcmp_mul64 u_mul_f1  (.i_clk(i_clk), .i_a(p9),    .i_b(ps), .o_p(m_f1));
    stcmp_mul64 u_mul_f2  (.i_clk(i_clk), .i_a(p8),    .i_b(r_p), .o_p(m_f2));
    stcmp_mul64 u_mul_g   (.i_clk(i_clk), .i_a(m_f1),  .i_b(r_sd[1]), .o_p(m_g));

    stcmp_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_ua),
        .i_den  (r_ub),
        .i_side (r_side),
        .o_quo  (quo),
        .o_side (div_side)
    );

    always_ff @(posedge i_clk) begin
        r_ap5d[0] <= m_ap5;
        r_ap5d[1] <= r_ap5d[0];
        r_ap2d[0] <= m_ap2;
        r_ap2d[1] <= r_ap2d[0];
        r_b  <= m_b1 + (r_ap5d[1] << 17) + (p4 << 35);
        r_a  <= sra64(m_a1, 8) + (r_ap2d[1] << 12);
        r_ua <= m_e[63] ? 64'(-m_e) : m_e;
        r_ub <= a_fin[63] ? 64'(-a_fin) : a_fin;
        r_side.neg  <= m_e[63] ^ a_fin[63];
        r_side.zero <= a_fin == 64'd0;
        r_p  <= div_side.neg ? 64'(-quo) : quo;
        r_zd[0] <= div_side.zero;
        for (int i = 1; i < 5; i++) r_zd[i] <= r_zd[i-1];
        r_pd[0] <= r_p;
        for (int i = 1; i < 4; i++) r_pd[i] <= r_pd[i-1];
        r_sd[0]  <= ps;
        r_sd[1]  <= r_sd[0];
        r_c2d[0] <= m_f2;
        r_c2d[1] <= r_c2d[0];
    end

    logic [63:0] pf;
    assign pf = sra64(r_pd[3] + sra64(m_g, 25) + sra64(r_c2d[1], 19), 8) + (p7 << 4);

    // align temperature and humidity with pressure
    logic [31:0] r_tfd  [TF_DLY];
    logic [31:0] r_tmpd [TMP_DLY];
    logic [16:0] r_humd [HUM_DLY];
    t_out        r_out;

    always_ff @(posedge i_clk) begin
        r_tfd[0]  <= r_tf;
        r_tmpd[0] <= r_temp;
        r_humd[0] <= r_hum;
        for (int i = 1; i < TF_DLY; i++)  r_tfd[i]  <= r_tfd[i-1];
        for (int i = 1; i < TMP_DLY; i++) r_tmpd[i] <= r_tmpd[i-1];
        for (int i = 1; i < HUM_DLY; i++) r_humd[i] <= r_humd[i-1];
        r_out.temperature      <= r_tmpd[TMP_DLY-1];
        r_out.fine_temperature <= r_tfd[TF_DLY-1];
        r_out.pressure         <= r_zd[4] ? 32'd0 : pf[31:0];
        r_out.pressure_invalid <= r_zd[4];
        r_out.humidity         <= r_humd[HUM_DLY-1];
    end

    assign o_valid  = r_vld[LAT];
    assign o_result = r_out;

    `STCMP_ASSERT_IMP(a_inv_zero, i_clk, i_rst_n, o_valid && o_result.pressure_invalid, o_result.pressure == 32'd0)
    `STCMP_ASSERT_IMP(a_hum_max, i_clk, i_rst_n, o_valid, o_result.humidity <= 17'd102400)
    `STCMP_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(acc, LAT))
    `STCMP_ASSERT_NXT(a_run, i_clk, i_rst_n, 1'b1, !busy)

endmodule
`default_nettype wire

// ----- tb/sv/sensor_temp_press_hum_compensation_tb.sv -----
// Testbench for the temperature / pressure / humidity compensation pipeline.
// Drives measurement sets and coefficient writes, predicts each result locally
// and compares it field by field. Depends on stcmp_pkg and the top level only.
`timescale 1ns / 1ps
`default_nettype none
module sensor_temp_press_hum_compensation_tb;
    import stcmp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_data = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    t_out        o_result;

    sensor_temp_press_hum_compensation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [47:0] coef_t;
    logic [63:0] coef_pl, coef_ph;
    logic [15:0] coef_p9;
    logic [39:0] coef_ha;
    logic [31:0] coef_hb;

    t_in  pending_sets[$];
    t_out expected_results[$];
    int   errors = 0;
    int   n_sets = 0;
    int   n_results = 0;
    int   n_invalid = 0;
    int   n_clamped = 0;
    longint unsigned cycles = 0;
    bit   quiet = 1'b0;
    int   gap = 0;

    function automatic logic signed [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_out compensate(t_in s);
        t_out r;
        logic signed [31:0] t1, t2, t3, v1, dd, v2, tf;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, ha, inn, hb, xs;
        logic signed [63:0] a, b, p, q, sc, c1, c2, ua, ub;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = {16'd0, coef_t[15:0]};
        t2 = {{16{coef_t[31]}}, coef_t[31:16]};
        t3 = {{16{coef_t[47]}}, coef_t[47:32]};
        v1 = $signed((({12'd0, s.adc_temp} >> 3) - (t1 << 1)) * t2) >>> 11;
        dd = ({12'd0, s.adc_temp} >> 4) - t1;
        v2 = (((dd * dd) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        r.fine_temperature = tf;
        r.temperature = (tf * 5 + 128) >>> 8;

        p1 = {48'd0, coef_pl[15:0]};
        p2 = sx16(coef_pl[31:16]); p3 = sx16(coef_pl[47:32]); p4 = sx16(coef_pl[63:48]);
        p5 = sx16(coef_ph[15:0]);  p6 = sx16(coef_ph[31:16]);
        p7 = sx16(coef_ph[47:32]); p8 = sx16(coef_ph[63:48]); p9 = sx16(coef_p9);
        a = 64'(tf) - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
        r.pressure = '0;
        r.pressure_invalid = 1'b1;
        if (a != 0) begin
            p = 64'sd1048576 - {44'd0, s.adc_press};
            p = ((p <<< 31) - b) * 64'sd3125;
            ua = p[63] ? -p : p;
            ub = a[63] ? -a : a;
            q = $signed($unsigned(ua) / $unsigned(ub));
            p = (p[63] != a[63]) ? -q : q;
            sc = p >>> 13;
            c1 = (p9 * sc * sc) >>> 25;
            c2 = (p8 * p) >>> 19;
            p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
            r.pressure = p[31:0];
            r.pressure_invalid = 1'b0;
        end

        h1 = {24'd0, coef_ha[7:0]};
        h2 = {{16{coef_ha[23]}}, coef_ha[23:8]};
        h3 = {24'd0, coef_ha[31:24]};
        h6 = {{24{coef_ha[39]}}, coef_ha[39:32]};
        h4 = {{16{coef_hb[15]}}, coef_hb[15:0]};
        h5 = {{16{coef_hb[31]}}, coef_hb[31:16]};
        x = tf - 32'sd76800;
        ha = $signed(({16'd0, s.adc_hum} << 14) - (h4 << 20) - (h5 * x) + 32'sd16384) >>> 15;
        inn = (((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768)) >>> 10;
        hb = ((inn + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
        x = ha * hb;
        xs = x >>> 15;
        x = x - ((((xs * xs) >>> 7) * h1) >>> 4);
        if (x < 0) x = 0;
        else if (x > 32'sd419430400) x = 32'sd419430400;
        r.humidity = 17'(x >>> 12);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(compensate(i_data));
                void'(pending_sets.pop_front());
                n_sets++;
            end
            if (gap > 0) begin
                gap <= gap - 1;
                start <= 1'b0;
            end else if (pending_sets.size() > 0 && !(start && busy)) begin
                if (!quiet && $urandom_range(0, 15) == 0) begin
                    gap <= $urandom_range(1, 8);
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_data <= pending_sets[0];
                end
            end else if (!(start && busy)) begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                t_out e;
                e = expected_results.pop_front();
                n_results++;
                if (e.pressure_invalid) n_invalid++;
                if (e.humidity == 0 || e.humidity == 17'd102400) n_clamped++;
                if (o_result.temperature !== e.temperature)
                    $display("%0t: temperature exp %0d got %0d", $time,
                             e.temperature, o_result.temperature);
                if (o_result.fine_temperature !== e.fine_temperature)
                    $display("%0t: fine_temperature exp %0d got %0d", $time,
                             e.fine_temperature, o_result.fine_temperature);
                if (o_result.pressure !== e.pressure)
                    $display("%0t: pressure exp %h got %h", $time,
                             e.pressure, o_result.pressure);
                if (o_result.pressure_invalid !== e.pressure_invalid)
                    $display("%0t: pressure_invalid exp %b got %b", $time,
                             e.pressure_invalid, o_result.pressure_invalid);
                if (o_result.humidity !== e.humidity)
                    $display("%0t: humidity exp %0d got %0d", $time,
                             e.humidity, o_result.humidity);
                if (o_result !== e) errors++;
            end
        end
        if (cycles > 2000000) begin
            $display("sensor_temp_press_hum_compensation verification failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TEMP:       coef_t  = val[47:0];
            CFG_PRESS_LOW:  coef_pl = val;
            CFG_PRESS_HIGH: coef_ph = val;
            CFG_PRESS_NINE: coef_p9 = val[15:0];
            CFG_HUM_A:      coef_ha = val[39:0];
            CFG_HUM_B:      coef_hb = val[31:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_sets.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // coefficient sets: typical, extremes, zero p1, perturbed typical, random
    task automatic load_coeffs(int mode);
        logic [63:0] r [6];
        for (int i = 0; i < 6; i++) r[i] = {$urandom, $urandom};
        case (mode)
            0: begin
                r[0] = 64'({16'd50, 16'd26435, 16'd27504});
                r[1] = {16'd2855, 16'hD0F8, 16'hD7D0, 16'd36477};
                r[2] = {16'hC0B6, 16'd15500, 16'hFFF9, 16'd140};
                r[3] = 64'd6000;
                r[4] = 64'({8'd30, 8'd0, 16'd362, 8'd75});
                r[5] = 64'({16'd50, 16'd313});
            end
            1: begin
                r[0] = 64'hFFFF_FFFF_FFFF;
                r[1] = '1; r[2] = '1; r[3] = 64'hFFFF; r[4] = '1; r[5] = '1;
            end
            2: begin
                r[0] = 64'h8000_8000_0000;
                r[1] = 64'h8000_8000_8000_0000;
                r[2] = 64'h8000_8000_8000_8000;
                r[3] = 64'h8000; r[4] = 64'h80_00_8000_00; r[5] = 64'h8000_8000;
            end
            3: r[1][15:0] = 16'd0;
            4: begin
                r[0] = 64'({16'd50, 16'd26435, 16'd27504} ^ 48'($urandom & 32'h1F));
                r[1] = {16'd2855, 16'hD0F8, 16'hD7D0,
                        16'(16'd36477 + $urandom_range(0, 500))};
                r[2][15:0] = 16'($urandom_range(0, 300));
                r[4] = 64'({8'd30, 8'd0, 16'd362, 8'd75} + 40'($urandom_range(0, 40)));
            end
            default: ;
        endcase
        write_reg(CFG_TEMP, r[0]);
        write_reg(CFG_PRESS_LOW, r[1]);
        write_reg(CFG_PRESS_HIGH, r[2]);
        write_reg(CFG_PRESS_NINE, r[3]);
        write_reg(CFG_HUM_A, r[4]);
        write_reg(CFG_HUM_B, r[5]);
    endtask

    function automatic t_in rand_set();
        t_in s;
        s.adc_temp  = 20'($urandom);
        s.adc_press = 20'($urandom);
        s.adc_hum   = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            s.adc_temp  = 20'($urandom_range(400000, 600000));
            s.adc_press = 20'($urandom_range(250000, 450000));
            s.adc_hum   = 16'($urandom_range(20000, 40000));
        end
        return s;
    endfunction

    initial begin
        coef_t = '0; coef_pl = '0; coef_ph = '0; coef_p9 = '0; coef_ha = '0; coef_hb = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset coefficients: divisor is zero
        pending_sets.push_back(t_in'{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        pending_sets.push_back(t_in'(0));
        drain();
        for (int m = 0; m < 6; m++) begin
            load_coeffs(m);
            pending_sets.push_back(t_in'(0));
            pending_sets.push_back(t_in'{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
            pending_sets.push_back(t_in'{20'd519888, 20'd415148, 16'd30000});
            pending_sets.push_back(t_in'{20'hAAAAA, 20'h55555, 16'hA5A5});
            for (int i = 0; i < 200; i++) pending_sets.push_back(rand_set());
            if (m == 5) quiet = 1'b1;
            drain();
        end
        $display("%0d sets checked over six coefficient settings", n_results);
        $display("%0d with zero pressure divisor, %0d at a humidity bound",
                 n_invalid, n_clamped);
        if (errors == 0 && expected_results.size() == 0)
            $display("sensor_temp_press_hum_compensation verification clean");
        else
            $display("sensor_temp_press_hum_compensation verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/stcmp_pkg.sv
rtl/stcmp_mul64.sv
rtl/stcmp_div.sv
rtl/sensor_temp_press_hum_compensation.sv
tb/sv/sensor_temp_press_hum_compensation_tb.sv
